// File: src/packet_pacing_rate_shaper_top_defines.svh
// ----------------------------------------------------------------------------
// Packet pacing rate shaper: assertion macros
// Shared concurrent assertion forms, clocked on aclk and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef PACKET_PACING_RATE_SHAPER_TOP_DEFINES_SVH
`define PACKET_PACING_RATE_SHAPER_TOP_DEFINES_SVH

// Same-cycle implication.
`define PPR_ASSERT_IMPLIES(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define PPR_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: src/ppr_pkg.sv
// ----------------------------------------------------------------------------
// Packet pacing rate shaper: package
// Widths, register indexes, constants and shared types.
// ----------------------------------------------------------------------------
package ppr_pkg;

    // Field and state widths.
    localparam int TIME_BITS = 63;
    localparam int RATE_BITS = 40;
    localparam int LEN_BITS  = 16;
    localparam int NS_BITS   = 34;
    localparam int PROD_BITS = LEN_BITS + NS_BITS;
    localparam int SLOT_W    = ((PROD_BITS > TIME_BITS) ? PROD_BITS : TIME_BITS) + 1;
    localparam int DIV_CNT_BITS = $clog2(PROD_BITS + 1);

    // Port widths.
    localparam int S_DATA_BITS = 80;
    localparam int M_DATA_BITS = 64;
    localparam int CFG_IDX_BITS  = 2;
    localparam int CFG_DATA_BITS = 40;

    // Nanoseconds times bits per byte.
    localparam logic [NS_BITS-1:0]   NS_PER_BYTE = NS_BITS'(64'd8000000000);
    localparam logic [TIME_BITS-1:0] TIME_MAX    = {TIME_BITS{1'b1}};
    localparam logic [LEN_BITS-1:0]  SMALL_RESET = LEN_BITS'(256);

    // Configuration register indexes.
    localparam logic [CFG_IDX_BITS-1:0] REG_DOWNLOAD_RATE = 2'd0;
    localparam logic [CFG_IDX_BITS-1:0] REG_UPLOAD_RATE   = 2'd1;
    localparam logic [CFG_IDX_BITS-1:0] REG_SMALL_BYTES   = 2'd2;

    // Divider status seen by the sequencer.
    typedef struct packed {
        logic busy;
        logic done;
    } div_stat_t;

endpackage

// File: src/ppr_div.sv
// ----------------------------------------------------------------------------
// Packet pacing rate shaper: bit-serial divider
// Restoring unsigned divider, one quotient bit per cycle over the product width.
// ----------------------------------------------------------------------------
module ppr_div (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          start,
    input  logic [ppr_pkg::PROD_BITS-1:0] dividend,
    input  logic [ppr_pkg::RATE_BITS-1:0] divisor,
    output logic [ppr_pkg::PROD_BITS-1:0] quotient,
    output ppr_pkg::div_stat_t            stat
);
    import ppr_pkg::*;

    logic [RATE_BITS-1:0]    rem_reg;
    logic [PROD_BITS-1:0]    quo_reg;
    logic [RATE_BITS-1:0]    dsr_reg;
    logic [DIV_CNT_BITS-1:0] cnt_reg;
    logic                    busy_reg;
    logic                    done_reg;

    logic [RATE_BITS:0]      trial;
    logic                    fits;
    logic [RATE_BITS:0]      diff;

    // Trial subtraction of the divisor from the shifted remainder.
    always_comb begin
        trial = {rem_reg, quo_reg[PROD_BITS-1]};
        fits  = (trial >= {1'b0, dsr_reg});
        diff  = trial - {1'b0, dsr_reg};
    end

    // Control: counter, busy and a one-cycle done pulse.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= DIV_CNT_BITS'(PROD_BITS);
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg - DIV_CNT_BITS'(1);
                if (cnt_reg == DIV_CNT_BITS'(1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // Datapath: remainder and dividend/quotient shift register.
    always_ff @(posedge aclk) begin
        if (start) begin
            rem_reg <= '0;
            quo_reg <= dividend;
            dsr_reg <= divisor;
        end else if (busy_reg) begin
            rem_reg <= fits ? diff[RATE_BITS-1:0] : trial[RATE_BITS-1:0];
            quo_reg <= {quo_reg[PROD_BITS-2:0], fits};
        end
    end

    assign quotient  = quo_reg;
    assign stat.busy = busy_reg;
    assign stat.done = done_reg;

endmodule

// File: src/packet_pacing_rate_shaper_top.sv
// ----------------------------------------------------------------------------
// Packet pacing rate shaper: top level
// Paces packets on a virtual send clock and returns the hold time per packet.
// ----------------------------------------------------------------------------
// A paced item passes from the check through the multiply, divider start, bit-serial divide
// and schedule states to the output register; an unpaced item goes from the check straight
// to the output register. One item at a time: the next is taken only once the previous
// result has entered the output register, which waits while the output is still held.
// Reset (aresetn low, synchronous) clears the schedule, rates and output valid,
// and sets the small-packet threshold to 256 bytes.
module packet_pacing_rate_shaper_top (
    input  logic                              aclk,
    input  logic                              aresetn,
    // Input items
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [ppr_pkg::S_DATA_BITS-1:0]   s_tdata,  // packet_length[15:0], now_ns[78:16]
    input  logic                              s_tuser,  // outbound
    // Result items
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [ppr_pkg::M_DATA_BITS-1:0]   m_tdata,  // wait_ns[62:0]
    // Configuration writes
    input  logic                              cfg_wr_en,
    input  logic [ppr_pkg::CFG_IDX_BITS-1:0]  cfg_index,
    input  logic [ppr_pkg::CFG_DATA_BITS-1:0] cfg_wr_data
);
    import ppr_pkg::*;

    `include "packet_pacing_rate_shaper_top_defines.svh"

    localparam logic [2:0] ST_IDLE   = 3'd0;
    localparam logic [2:0] ST_CHECK  = 3'd1;
    localparam logic [2:0] ST_MUL    = 3'd2;
    localparam logic [2:0] ST_DSTART = 3'd3;
    localparam logic [2:0] ST_DIV    = 3'd4;
    localparam logic [2:0] ST_SCHED  = 3'd5;
    localparam logic [2:0] ST_FIN    = 3'd6;

    logic [2:0]           state_reg, state_next;

    logic [RATE_BITS-1:0] down_rate_reg;
    logic [RATE_BITS-1:0] up_rate_reg;
    logic [LEN_BITS-1:0]  small_reg;

    logic [RATE_BITS-1:0] last_rate_reg;
    logic [TIME_BITS-1:0] next_free_reg;

    logic [LEN_BITS-1:0]  len_reg;
    logic                 outbound_reg;
    logic [TIME_BITS-1:0] now_reg;
    logic [RATE_BITS-1:0] rate_reg;
    logic [PROD_BITS-1:0] prod_reg;
    logic [TIME_BITS-1:0] slot_reg;
    logic [TIME_BITS-1:0] wait_reg;

    logic                 m_valid_reg;
    logic [TIME_BITS-1:0] m_wait_reg;

    logic [RATE_BITS-1:0] rate_sel;
    logic                 unpaced;
    logic                 arrived_late;
    logic [TIME_BITS-1:0] add_base;
    logic [TIME_BITS:0]   add_sum;
    logic [TIME_BITS-1:0] add_sat;
    logic [SLOT_W-1:0]    quo_wide;
    logic [TIME_BITS-1:0] slot_clamped;
    logic                 in_accept;
    logic                 out_free;

    logic                 div_start;
    logic [PROD_BITS-1:0] div_quotient;
    div_stat_t            div_stat;

    assign in_accept = s_tvalid && s_tready;
    assign out_free  = !m_valid_reg || m_tready;
    assign div_start = (state_reg == ST_DSTART);

    // Shared divider for the send slot.
    ppr_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (prod_reg),
        .divisor  (rate_reg),
        .quotient (div_quotient),
        .stat     (div_stat)
    );

    // Rate selection and the unpaced test.
    always_comb begin
        rate_sel = outbound_reg ? up_rate_reg : down_rate_reg;
        unpaced  = (rate_sel == '0) || (len_reg <= small_reg);
    end

    // Slot clamp to the time range.
    always_comb begin
        quo_wide     = SLOT_W'(div_quotient);
        slot_clamped = (quo_wide > SLOT_W'(TIME_MAX)) ? TIME_MAX
                                                      : quo_wide[TIME_BITS-1:0];
    end

    // Saturating add of the slot onto now or onto the free time.
    always_comb begin
        arrived_late = (now_reg >= next_free_reg);
        add_base     = arrived_late ? now_reg : next_free_reg;
        add_sum      = {1'b0, add_base} + {1'b0, slot_reg};
        add_sat      = add_sum[TIME_BITS] ? TIME_MAX : add_sum[TIME_BITS-1:0];
    end

    // Sequencer.
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:   if (in_accept) state_next = ST_CHECK;
            ST_CHECK:  state_next = unpaced ? ST_FIN : ST_MUL;
            ST_MUL:    state_next = ST_DSTART;
            ST_DSTART: state_next = ST_DIV;
            ST_DIV:    if (div_stat.done) state_next = ST_SCHED;
            ST_SCHED:  state_next = ST_FIN;
            ST_FIN:    if (out_free) state_next = ST_IDLE;
            default:   state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // Configuration registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            down_rate_reg <= '0;
            up_rate_reg   <= '0;
            small_reg     <= SMALL_RESET;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                REG_DOWNLOAD_RATE: down_rate_reg <= cfg_wr_data[RATE_BITS-1:0];
                REG_UPLOAD_RATE:   up_rate_reg   <= cfg_wr_data[RATE_BITS-1:0];
                REG_SMALL_BYTES:   small_reg     <= cfg_wr_data[LEN_BITS-1:0];
                default: ;
            endcase
        end
    end

    // Pacing state: last rate and the virtual free time.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            last_rate_reg <= '0;
            next_free_reg <= '0;
        end else if (state_reg == ST_CHECK && !unpaced && rate_sel != last_rate_reg) begin
            last_rate_reg <= rate_sel;
            next_free_reg <= now_reg;
        end else if (state_reg == ST_SCHED) begin
            next_free_reg <= add_sat;
        end
    end

    // Item datapath registers.
    always_ff @(posedge aclk) begin
        if (in_accept) begin
            len_reg      <= s_tdata[LEN_BITS-1:0];
            now_reg      <= s_tdata[LEN_BITS +: TIME_BITS];
            outbound_reg <= s_tuser;
        end
        if (state_reg == ST_CHECK) begin
            rate_reg <= rate_sel;
            wait_reg <= '0;
        end
        if (state_reg == ST_MUL) begin
            prod_reg <= PROD_BITS'(len_reg) * PROD_BITS'(NS_PER_BYTE);
        end
        if (state_reg == ST_DIV && div_stat.done) begin
            slot_reg <= slot_clamped;
        end
        if (state_reg == ST_SCHED) begin
            wait_reg <= arrived_late ? '0 : (next_free_reg - now_reg);
        end
    end

    // Output register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (state_reg == ST_FIN && out_free) begin
            m_valid_reg <= 1'b1;
        end else if (m_tready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (state_reg == ST_FIN && out_free) begin
            m_wait_reg <= wait_reg;
        end
    end

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = m_valid_reg;
    assign m_tdata  = M_DATA_BITS'(m_wait_reg);

    // Checks on the sequencer and the divider hand-off.
    `PPR_ASSERT_NEXT(a_accept_drops_ready, s_tvalid && s_tready, !s_tready, "ready after accept")
    `PPR_ASSERT_IMPLIES(a_start_not_busy, div_start, !div_stat.busy, "divider restarted while busy")
    `PPR_ASSERT_IMPLIES(a_done_in_div, div_stat.done, state_reg == ST_DIV, "stray divider done")
    `PPR_ASSERT_IMPLIES(a_out_from_fin, $rose(m_tvalid), $past(state_reg) == ST_FIN, "stray result")

endmodule

// File: tb/testbench.sv
// ----------------------------------------------------------------------------
// Packet pacing rate shaper: self-checking testbench
// Drives packet items with their length, direction and timestamp, and writes
// the rate and threshold registers between phases. A scoreboard keeps its own
// copy of the virtual send schedule, predicts the hold time of every accepted
// item and compares it with each result, in order. Both sides of the stream
// idle at random; the receiver also holds off once for a long stretch.
// ----------------------------------------------------------------------------
module testbench;
    import ppr_pkg::*;

    localparam int CLK_HALF       = 6;
    localparam int RESET_CYCLES   = 9;
    localparam int SETTLE_CYCLES  = 64;
    localparam int PHASES         = 12;
    localparam int PHASE_ITEMS    = 160;
    localparam int TAIL_ITEMS     = 150;
    localparam int LONG_HOLD      = 300;
    localparam int REPORT_LIMIT   = 10;
    localparam longint WATCHDOG_CYCLES = 1000000;

    localparam logic [CFG_IDX_BITS-1:0]  REG_UNUSED = 2'd3;
    localparam logic [RATE_BITS-1:0]     RATE_MAX   = {RATE_BITS{1'b1}};
    localparam logic [LEN_BITS-1:0]      LEN_MAX    = {LEN_BITS{1'b1}};

    // Scoreboard: holds its own copy of the registers and of the schedule,
    // and the queue of hold times still owed by the block.
    class pacing_scoreboard;
        logic [RATE_BITS-1:0] download_rate;
        logic [RATE_BITS-1:0] upload_rate;
        logic [LEN_BITS-1:0]  small_bytes;
        logic [RATE_BITS-1:0] last_rate;
        logic [TIME_BITS-1:0] next_free;
        logic [TIME_BITS-1:0] expected_holds[$];
        int unsigned          failures;

        function new();
            download_rate = '0;
            upload_rate   = '0;
            small_bytes   = SMALL_RESET;
            last_rate     = '0;
            next_free     = '0;
            failures      = 0;
        endfunction

        function void write_reg(logic [CFG_IDX_BITS-1:0] idx,
                                logic [CFG_DATA_BITS-1:0] value);
            case (idx)
                REG_DOWNLOAD_RATE: download_rate = value[RATE_BITS-1:0];
                REG_UPLOAD_RATE:   upload_rate   = value[RATE_BITS-1:0];
                REG_SMALL_BYTES:   small_bytes   = value[LEN_BITS-1:0];
                default: ;
            endcase
        endfunction

        // Time sums clamp at the top of the timestamp range.
        function logic [TIME_BITS-1:0] add_sat(logic [TIME_BITS-1:0] a, logic [63:0] b);
            logic [64:0] s;
            s = {2'b00, a} + {1'b0, b};
            return (s > {2'b00, TIME_MAX}) ? TIME_MAX : s[TIME_BITS-1:0];
        endfunction

        // Works out the hold time of one packet and advances the schedule.
        function logic [TIME_BITS-1:0] predict_hold(logic [LEN_BITS-1:0] len,
                                                    logic outbound,
                                                    logic [TIME_BITS-1:0] now);
            logic [RATE_BITS-1:0] rate;
            logic [63:0]          slot;
            logic [TIME_BITS-1:0] hold;
            rate = outbound ? upload_rate : download_rate;
            // Unpaced: zero rate or a small packet leaves the schedule alone.
            if (rate == '0 || len <= small_bytes)
                return '0;
            // A new rate restarts the schedule at the arrival time.
            if (rate != last_rate) begin
                last_rate = rate;
                next_free = now;
            end
            slot = (64'(len) * 64'(NS_PER_BYTE)) / 64'(rate);
            if (slot > 64'(TIME_MAX))
                slot = 64'(TIME_MAX);
            if (now >= next_free) begin
                next_free = add_sat(now, slot);
                return '0;
            end
            // Early arrival, or time going backwards: wait for the free slot.
            hold      = next_free - now;
            next_free = add_sat(next_free, slot);
            return hold;
        endfunction

        function void note_packet(logic [LEN_BITS-1:0] len, logic outbound,
                                  logic [TIME_BITS-1:0] now);
            expected_holds.push_back(predict_hold(len, outbound, now));
        endfunction

        function void report(string what, logic [TIME_BITS-1:0] want,
                             logic [TIME_BITS-1:0] got);
            failures++;
            if (failures <= REPORT_LIMIT)
                $display("%0t: %s: expected wait_ns %0d, got %0d", $time, what, want, got);
        endfunction

        function void check_hold(logic [M_DATA_BITS-1:0] tdata);
            logic [TIME_BITS-1:0] want;
            if (expected_holds.size() == 0) begin
                report("result with no item outstanding", '0, tdata[TIME_BITS-1:0]);
                return;
            end
            want = expected_holds.pop_front();
            if (tdata[TIME_BITS-1:0] !== want)
                report("wait_ns mismatch", want, tdata[TIME_BITS-1:0]);
        endfunction
    endclass

    logic                     aclk;
    logic                     aresetn;
    logic                     s_tvalid;
    logic                     s_tready;
    logic [S_DATA_BITS-1:0]   s_tdata;   // packet_length[15:0], now_ns[78:16]
    logic                     s_tuser;   // outbound
    logic                     m_tvalid;
    logic                     m_tready;
    logic [M_DATA_BITS-1:0]   m_tdata;   // wait_ns[62:0]
    logic                     cfg_wr_en;
    logic [CFG_IDX_BITS-1:0]  cfg_index;
    logic [CFG_DATA_BITS-1:0] cfg_wr_data;

    pacing_scoreboard sb;
    bit               tail_phase;
    int               hold_off_cycles;

    packet_pacing_rate_shaper_top dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_index   (cfg_index),
        .cfg_wr_data (cfg_wr_data)
    );

    // Clock.
    initial begin
        aclk = 1'b0;
        forever #CLK_HALF aclk = ~aclk;
    end

    // Watchdog.
    initial begin
        #(WATCHDOG_CYCLES * 2 * CLK_HALF);
        $display("testbench NOT OK");
        $finish;
    end

    // Monitor: register writes, accepted items and accepted results.
    always @(posedge aclk) begin
        if (aresetn) begin
            if (cfg_wr_en)
                sb.write_reg(cfg_index, cfg_wr_data);
            if (s_tvalid && s_tready)
                sb.note_packet(s_tdata[LEN_BITS-1:0], s_tuser,
                               s_tdata[LEN_BITS +: TIME_BITS]);
            if (m_tvalid && m_tready)
                sb.check_hold(m_tdata);
        end
    end

    // Result receiver: random stalls, open stretches and one long hold-off.
    initial begin
        m_tready <= 1'b0;
        @(posedge aclk);
        while (!aresetn)
            @(posedge aclk);
        forever begin
            if (hold_off_cycles > 0) begin
                m_tready <= 1'b0;
                repeat (hold_off_cycles) @(posedge aclk);
                hold_off_cycles = 0;
            end else if (!tail_phase && $urandom_range(0, 4) == 0) begin
                m_tready <= 1'b0;
                repeat ($urandom_range(1, 4)) @(posedge aclk);
            end else begin
                m_tready <= 1'b1;
                repeat ($urandom_range(1, 12)) @(posedge aclk);
            end
        end
    end

    // Offers one packet item, with an occasional idle burst ahead of it.
    task automatic send_packet(input logic [LEN_BITS-1:0] len, input logic outbound,
                               input logic [TIME_BITS-1:0] now);
        if (!tail_phase && $urandom_range(0, 5) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {1'b0, now, len};
        s_tuser  <= outbound;
        do @(posedge aclk); while (!s_tready);
    endtask

    // The queue is looked at only after an edge, once the monitor has noted
    // the item accepted at the edge before.
    task automatic wait_drained();
        do @(posedge aclk); while (sb.expected_holds.size() != 0);
    endtask

    // Register writes happen only once the block has gone quiet.
    task automatic configure(input logic [RATE_BITS-1:0] dl, input logic [RATE_BITS-1:0] ul,
                             input logic [LEN_BITS-1:0] small_len, input bit poke_unused);
        s_tvalid <= 1'b0;
        wait_drained();
        repeat (SETTLE_CYCLES) @(posedge aclk);
        cfg_wr_en   <= 1'b1;
        cfg_index   <= REG_DOWNLOAD_RATE;
        cfg_wr_data <= CFG_DATA_BITS'(dl);
        @(posedge aclk);
        cfg_index   <= REG_UPLOAD_RATE;
        cfg_wr_data <= CFG_DATA_BITS'(ul);
        @(posedge aclk);
        cfg_index   <= REG_SMALL_BYTES;
        cfg_wr_data <= CFG_DATA_BITS'(small_len);
        @(posedge aclk);
        if (poke_unused) begin
            cfg_index   <= REG_UNUSED;
            cfg_wr_data <= CFG_DATA_BITS'({$urandom, $urandom});
            @(posedge aclk);
        end
        cfg_wr_en <= 1'b0;
    endtask

    function automatic logic [RATE_BITS-1:0] pick_rate();
        logic [63:0] r;
        r = {$urandom, $urandom};
        case ($urandom_range(0, 7))
            0:       return '0;
            1:       return RATE_BITS'(1);
            2:       return RATE_MAX;
            3, 4:    return RATE_BITS'($urandom_range(1000000, 32'hFFFF_FFFF));
            default: return r[RATE_BITS-1:0];
        endcase
    endfunction

    // Stimulus.
    initial begin
        logic [RATE_BITS-1:0] dl;
        logic [RATE_BITS-1:0] ul;
        logic [LEN_BITS-1:0]  small_len;
        logic [LEN_BITS-1:0]  len;
        logic [TIME_BITS-1:0] now_ns;
        logic [63:0]          r;
        logic [64:0]          t;
        logic                 dir;
        int                   phase;
        int                   n;
        int                   k;
        int                   burst;
        int                   sent;

        sb              = new();
        tail_phase      = 1'b0;
        hold_off_cycles = 0;
        aresetn     <= 1'b0;
        s_tvalid    <= 1'b0;
        s_tdata     <= '0;
        s_tuser     <= 1'b0;
        cfg_wr_en   <= 1'b0;
        cfg_index   <= REG_DOWNLOAD_RATE;
        cfg_wr_data <= '0;
        repeat (RESET_CYCLES) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed: rates still zero after reset, so nothing is paced.
        send_packet(16'd1500, 1'b0, 63'd100);
        configure(40'd1000000000, 40'd500000000, 16'd256, 1'b0);
        // Threshold boundary, then the first paced packet restarts the schedule.
        send_packet(16'd256, 1'b0, 63'd1000);
        send_packet(16'd257, 1'b0, 63'd1000);
        send_packet(16'd1500, 1'b0, 63'd1500);
        send_packet(LEN_MAX, 1'b0, 63'd1500);
        // Direction change switches rate; zero length is always small.
        send_packet(16'd1500, 1'b1, 63'd2000);
        send_packet(16'd0, 1'b1, 63'd2000);
        // Time going backwards.
        send_packet(16'd1500, 1'b1, 63'd1900);
        // Saturation at the top of the time range.
        send_packet(LEN_MAX, 1'b1, TIME_MAX - 63'd100);
        send_packet(16'd300, 1'b1, TIME_MAX - 63'd50);
        send_packet(16'd300, 1'b1, TIME_MAX);
        send_packet(LEN_MAX, 1'b1, 63'd0);
        // Slowest and fastest rates, no small-packet exemption.
        configure(RATE_BITS'(1), RATE_MAX, 16'd0, 1'b1);
        send_packet(16'd1, 1'b0, 63'd5);
        send_packet(LEN_MAX, 1'b0, 63'd6);
        send_packet(16'd1, 1'b1, 63'd7);
        send_packet(LEN_MAX, 1'b1, 63'd7);
        // Every length counts as small.
        configure(RATE_MAX, RATE_MAX, LEN_MAX, 1'b0);
        send_packet(LEN_MAX, 1'b0, 63'd10);
        send_packet(LEN_MAX, 1'b1, 63'd11);

        // Random phases: each picks a fresh register setting.
        sent   = 0;
        now_ns = '0;
        for (phase = 0; phase < PHASES; phase++) begin
            dl        = pick_rate();
            ul        = ($urandom_range(0, 3) == 0) ? dl : pick_rate();
            small_len = ($urandom_range(0, 1) == 0) ? LEN_BITS'($urandom_range(0, 1600))
                                                    : LEN_BITS'($urandom);
            case (phase)
                0: begin
                    dl        = RATE_BITS'(1);
                    ul        = RATE_MAX;
                    small_len = '0;
                end
                1: begin
                    dl = '0;
                    ul = '0;
                end
                2:       small_len = LEN_MAX;
                3:       small_len = SMALL_RESET;
                default: ;
            endcase
            configure(dl, ul, small_len, phase == 4);

            n = 0;
            while (n < PHASE_ITEMS) begin
                // Each run of packets may start from a fresh point in time.
                r = {$urandom, $urandom};
                case ($urandom_range(0, 19))
                    0:       now_ns = r[TIME_BITS-1:0];
                    1:       now_ns = TIME_MAX - TIME_BITS'($urandom_range(0, 1000000));
                    default: ;
                endcase
                burst = $urandom_range(1, 24);
                dir   = 1'($urandom_range(0, 1));
                k     = 0;
                while (k < burst && n < PHASE_ITEMS) begin
                    if ($urandom_range(0, 4) == 0)
                        dir = ~dir;
                    case ($urandom_range(0, 7))
                        0:       len = LEN_BITS'($urandom_range(0, small_len));
                        1:       len = small_len + 16'd1;
                        2:       len = LEN_MAX;
                        3:       len = 16'd1500;
                        default: len = LEN_BITS'($urandom);
                    endcase
                    r = {$urandom, $urandom};
                    case ($urandom_range(0, 9))
                        0:       t = {2'b00, now_ns};
                        1, 2, 3: t = {2'b00, now_ns} + $urandom_range(0, 2000);
                        4, 5, 6: t = {2'b00, now_ns} + $urandom_range(0, 200000);
                        7:       t = {2'b00, now_ns} + $urandom;
                        8:       t = {2'b00, now_ns} + (r >> 20);
                        default: begin
                            // Timestamp steps back a little.
                            t = {2'b00, now_ns} - $urandom_range(0, 5000);
                            if (t[64])
                                t = '0;
                        end
                    endcase
                    now_ns = (t > {2'b00, TIME_MAX}) ? TIME_MAX : t[TIME_BITS-1:0];
                    send_packet(len, dir, now_ns);
                    sent++;
                    n++;
                    k++;
                    if (sent == PHASES * PHASE_ITEMS - TAIL_ITEMS)
                        tail_phase = 1'b1;
                    // Long receiver hold-off while items keep coming.
                    if (phase == 3 && n == 20)
                        hold_off_cycles = LONG_HOLD;
                    // Sender pause until everything owed has arrived.
                    if (phase == 5 && n == 40) begin
                        s_tvalid <= 1'b0;
                        wait_drained();
                    end
                end
            end
        end

        s_tvalid <= 1'b0;
        wait_drained();
        repeat (SETTLE_CYCLES) @(posedge aclk);
        if (sb.failures == 0 && sb.expected_holds.size() == 0)
            $display("testbench OK");
        else
            $display("testbench NOT OK");
        $finish;
    end
endmodule

// File: packet_pacing_rate_shaper_top.f
+incdir+src
src/ppr_pkg.sv
src/ppr_div.sv
src/packet_pacing_rate_shaper_top.sv
tb/testbench.sv
